[sv/cursor_linked_list_engine_defines.svh]
// Assertion helpers; expect clk and arst_n in the including scope.
`ifndef CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH

`define CLLE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clle: same-cycle check failed");

`define CLLE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clle: next-cycle check failed");

`endif

[sv/clle_pkg.sv]
package clle_pkg;

	localparam int NODES_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEEK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESP
	} state_t;

	// wavefront control handed from cell to cell
	typedef struct packed {
		logic act;
		op_t  op;
	} ctrl_t;

endpackage

[sv/clle_cell.sv]
module clle_cell
	import clle_pkg::*;
#(
	parameter int IW   = 6,
	parameter int DW   = 32,
	parameter int SLOT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl_in,
	input  logic [IW-1:0] pos_in,
	input  logic [DW-1:0] carry_in,
	input  logic [DW-1:0] nbr_data,
	output ctrl_t         ctrl_out,
	output logic [IW-1:0] pos_out,
	output logic [DW-1:0] carry_out,
	output logic [DW-1:0] data_out
);

	// 1-based list position held by this cell
	localparam logic [IW-1:0] PLACE = IW'(SLOT + 1);

	ctrl_t         ctrl_q;
	logic [IW-1:0] pos_q;
	logic [DW-1:0] carry_q;
	logic [DW-1:0] data_q;
	logic [DW-1:0] data_d;
	logic [DW-1:0] carry_d;
	logic          at_or_after;
	logic          at_pos;

	assign at_or_after = (PLACE >= pos_in);
	assign at_pos      = (PLACE == pos_in);

	always_comb begin
		data_d  = data_q;
		carry_d = carry_in;
		if (ctrl_in.act) begin
			unique case (ctrl_in.op)
				OP_INSERT: begin
					if (at_or_after) begin
						data_d  = carry_in;
						carry_d = data_q;
					end
				end
				OP_DELETE: begin
					if (at_or_after) begin
						data_d = nbr_data;
					end
				end
				OP_SEEK: begin
					if (at_pos) begin
						carry_d = data_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_in;
		carry_q <= carry_d;
		data_q  <= data_d;
	end

	assign ctrl_out  = ctrl_q;
	assign pos_out   = pos_q;
	assign carry_out = carry_q;
	assign data_out  = data_q;

endmodule

[sv/cursor_linked_list_engine.sv]
// Ordered list of up to NODES-2 data words with insert, delete and seek at a
// 1-based position; each transaction returns one result with a status, the
// word read (seek only, otherwise zero) and the length after the operation.
// The list lives in a row of NODES-2 cells, one element per cell in list
// order. An accepted operation that passes its range and capacity checks
// launches a wavefront that moves one cell per cycle down the row, shifting
// elements for insert and delete or picking up the word for a seek, and its
// result is presented once the wavefront has left the last cell. A rejected
// operation answers in the cycle after acceptance. One transaction is in
// flight at a time; input is taken again once the result has been taken.
`include "cursor_linked_list_engine_defines.svh"

module cursor_linked_list_engine
	import clle_pkg::*;
#(
	parameter int NODES      = NODES_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic [$clog2(NODES)-1:0] position,
	input  logic [DATA_WIDTH-1:0]    value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [DATA_WIDTH-1:0]    read_value,
	output logic [$clog2(NODES)-1:0] length
);

	localparam int IW  = $clog2(NODES);
	localparam int DW  = DATA_WIDTH;
	localparam int CAP = NODES - 2;
	localparam logic [IW-1:0] CAP_W = IW'(CAP);

	state_t          state_q;
	state_t          state_d;
	logic [IW-1:0]   count_q;
	logic [IW-1:0]   count_d;
	ctrl_t           launch_q;
	logic [IW-1:0]   pos_q;
	logic [DW-1:0]   carry_q;
	logic [1:0]      status_q;
	logic [DW-1:0]   read_value_q;
	logic [IW-1:0]   length_q;

	logic            accept;
	logic            deliver;
	logic            go;
	status_t         chk_status;
	logic [IW:0]     pos_ext;
	logic [IW:0]     cnt_ext;

	ctrl_t           ctrl_c  [0:CAP];
	logic [IW-1:0]   pos_c   [0:CAP];
	logic [DW-1:0]   carry_c [0:CAP];
	logic [DW-1:0]   data_c  [0:CAP-1];

	assign accept  = in_valid && in_ready;
	assign deliver = out_valid && out_ready;
	assign pos_ext = {1'b0, position};
	assign cnt_ext = {1'b0, count_q};

	// range check first, then capacity
	always_comb begin
		chk_status = ST_DONE;
		go         = 1'b0;
		count_d    = count_q;
		unique case (req_type)
			OP_INSERT: begin
				if (position == '0 || pos_ext > cnt_ext + (IW+1)'(1)) begin
					chk_status = ST_RANGE;
				end else if (count_q == CAP_W) begin
					chk_status = ST_FULL;
				end else begin
					go      = 1'b1;
					count_d = count_q + IW'(1);
				end
			end
			OP_DELETE: begin
				if (position == '0 || pos_ext > cnt_ext) begin
					chk_status = ST_RANGE;
				end else begin
					go      = 1'b1;
					count_d = count_q - IW'(1);
				end
			end
			OP_SEEK: begin
				if (position == '0 || pos_ext > cnt_ext) begin
					chk_status = ST_RANGE;
				end else begin
					go = 1'b1;
				end
			end
			default: begin
				chk_status = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = go ? S_WALK : S_RESP;
				end
			end
			S_WALK: begin
				if (ctrl_c[CAP].act) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready  = 1'b1;
			S_RESP:  out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			launch_q <= '0;
		end else begin
			state_q      <= state_d;
			launch_q.act <= accept && go;
			launch_q.op  <= op_t'(req_type);
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q        <= position;
			carry_q      <= value;
			status_q     <= chk_status;
			read_value_q <= '0;
			length_q     <= count_d;
		end else if (state_q == S_WALK && ctrl_c[CAP].act && ctrl_c[CAP].op == OP_SEEK) begin
			read_value_q <= carry_c[CAP];
		end
	end

	assign ctrl_c[0]  = launch_q;
	assign pos_c[0]   = pos_q;
	assign carry_c[0] = carry_q;

	for (genvar k = 0; k < CAP; k++) begin : g_cell
		logic [DW-1:0] nbr;
		if (k == CAP - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = data_c[k+1];
		end
		clle_cell #(
			.IW   (IW),
			.DW   (DW),
			.SLOT (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl_in   (ctrl_c[k]),
			.pos_in    (pos_c[k]),
			.carry_in  (carry_c[k]),
			.nbr_data  (nbr),
			.ctrl_out  (ctrl_c[k+1]),
			.pos_out   (pos_c[k+1]),
			.carry_out (carry_c[k+1]),
			.data_out  (data_c[k])
		);
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;

	`CLLE_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CAP_W)
	`CLLE_ASSERT_IMP(a_tail_in_walk, ctrl_c[CAP].act, state_q == S_WALK)
	`CLLE_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE)
	`CLLE_ASSERT_IMP(a_rd_zero, out_valid && status_q != ST_DONE, read_value_q == '0)

endmodule

[dv/tb.sv]
module tb
	import clle_pkg::*;
();

	localparam int          CAPACITY    = NODES_DEF - 2;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          ITEM_TOTAL  = 1050;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;

	typedef struct {
		status_t     st;
		logic [31:0] rd;
		logic [5:0]  len;
	} outcome_t;

	class list_tracker;
		logic [31:0] words[$];
		outcome_t    due_results[$];
		int          failures;

		function int list_len();
			return words.size();
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_request(logic [1:0] op, logic [5:0] pos, logic [31:0] val);
			outcome_t o;
			int       n;
			n    = words.size();
			o.st = ST_DONE;
			o.rd = '0;
			case (op)
				OP_INSERT: begin
					if (pos == 0 || pos > n + 1)
						o.st = ST_RANGE;
					else if (n >= CAPACITY)
						o.st = ST_FULL;
					else
						words.insert(pos - 1, val);
				end
				OP_DELETE: begin
					if (pos == 0 || pos > n)
						o.st = ST_RANGE;
					else
						words.delete(pos - 1);
				end
				OP_SEEK: begin
					if (pos == 0 || pos > n)
						o.st = ST_RANGE;
					else
						o.rd = words[pos - 1];
				end
				default: o.st = ST_RANGE;
			endcase
			o.len = 6'(words.size());
			due_results.push_back(o);
		endfunction

		function void mismatch(string msg);
			if (failures < 10)
				$display("mismatch: %s", msg);
			failures++;
		endfunction

		function void check_result(logic [1:0] st, logic [31:0] rd, logic [5:0] len);
			outcome_t want;
			if (due_results.size() == 0) begin
				mismatch($sformatf("unexpected result status %0d read_value %h length %0d",
					st, rd, len));
				return;
			end
			want = due_results.pop_front();
			if (st !== want.st)
				mismatch($sformatf("status exp %0d got %0d", want.st, st));
			if (rd !== want.rd)
				mismatch($sformatf("read_value exp %h got %h", want.rd, rd));
			if (len !== want.len)
				mismatch($sformatf("length exp %0d got %0d", want.len, len));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [5:0]  position;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic [5:0]  length;

	list_tracker board = new();
	int          sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          cycles = 0;

	cursor_linked_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.read_value(read_value),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(status, read_value, length);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_req(input logic [1:0] op, input logic [5:0] pos, input logic [31:0] val);
		if (sent < 350) begin
			send_idle_pct = 29;
			recv_idle_pct = 81;
		end else if (sent < 700) begin
			send_idle_pct = 81;
			recv_idle_pct = 29;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(op, pos, val);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		logic [1:0]  op;
		logic [5:0]  pos;
		logic [31:0] val;
		int          n;
		int          top;
		int          pick;
		bit          filling;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = OP_INSERT;
		position      = '0;
		value         = '0;
		sent          = 0;
		send_idle_pct = 29;
		recv_idle_pct = 81;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, bounds and basic ordering
		send_req(OP_SEEK,   6'd1,  32'h0000_0001);
		send_req(OP_DELETE, 6'd1,  32'h0);
		send_req(OP_INSERT, 6'd0,  32'h1111_1111);
		send_req(OP_INSERT, 6'd2,  32'h2222_2222);
		send_req(OP_INSERT, 6'd1,  32'h0000_0000);
		send_req(OP_INSERT, 6'd1,  32'hffff_ffff);
		send_req(OP_INSERT, 6'd3,  32'ha5a5_a5a5);
		send_req(OP_INSERT, 6'd2,  32'h1234_5678);
		send_req(OP_SEEK,   6'd1,  32'h0);
		send_req(OP_SEEK,   6'd2,  32'h0);
		send_req(OP_SEEK,   6'd3,  32'h0);
		send_req(OP_SEEK,   6'd4,  32'hffff_ffff);
		send_req(OP_SEEK,   6'd5,  32'h0);
		send_req(OP_SEEK,   6'd0,  32'h0);
		send_req(OP_UNUSED, 6'd1,  32'h5a5a_5a5a);
		send_req(OP_INSERT, 6'd63, 32'hdead_beef);
		send_req(OP_DELETE, 6'd63, 32'h0);
		send_req(OP_DELETE, 6'd2,  32'h0);
		send_req(OP_SEEK,   6'd2,  32'h0);
		send_req(OP_DELETE, 6'd3,  32'h0);
		send_req(OP_DELETE, 6'd1,  32'h0);
		send_req(OP_SEEK,   6'd1,  32'h0);
		send_req(OP_UNUSED, 6'd63, 32'hffff_ffff);

		// drain before random traffic
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.pending() != 0)
			@(negedge clk);

		filling = 1'b1;
		while (sent < ITEM_TOTAL) begin
			n = board.list_len();
			if (filling && n == CAPACITY && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (!filling && n == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
			pick = $urandom_range(99);
			if (pick < 4)
				op = OP_UNUSED;
			else if (pick < (filling ? 66 : 26))
				op = OP_INSERT;
			else if (pick < 80)
				op = OP_DELETE;
			else
				op = OP_SEEK;
			if ($urandom_range(9) == 0 || (op != OP_INSERT && n == 0)) begin
				pos = 6'($urandom_range(63));
			end else begin
				top = (op == OP_INSERT) ? n + 1 : n;
				case ($urandom_range(5))
					0:       pos = 6'd1;
					1:       pos = 6'(top);
					default: pos = 6'($urandom_range(top, 1));
				endcase
			end
			case ($urandom_range(9))
				0:       val = 32'h0;
				1:       val = 32'hffff_ffff;
				default: val = $urandom;
			endcase
			send_req(op, pos, val);
		end
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[sim.f]
+incdir+sv
sv/clle_pkg.sv
sv/clle_cell.sv
sv/cursor_linked_list_engine.sv
dv/tb.sv
